/* design/linear_probe_hash_index_top_assert.svh */
// ----------------------------------------------------------------------------
// Linear probe hash index assertion macros
// Concurrent assertion macros used by the hash index top module.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_INDEX_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_INDEX_TOP_ASSERT_SVH

`ifndef SYNTH

`define LPHI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hash index assertion failed");

`define LPHI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hash index assertion failed");

`else

`define LPHI_ASSERT_IMPL(label, clk, rst, ante, cons)

`define LPHI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* design/lphi_pkg.sv */
// ----------------------------------------------------------------------------
// Linear probe hash index package
// Sizes, codes and payload types shared by the hash index modules.
// ----------------------------------------------------------------------------
package lphi_pkg;

   // The home slot is the key's low bits, so the table size is a power of two.
   localparam int TableSize    = 16;
   localparam int SlotBits     = $clog2(TableSize);
   localparam int KeyWidth     = 17;
   localparam int OffsetWidth  = 24;
   localparam int SlotOutWidth = 4;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_SEARCH = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_FOUND     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      command_type             command;
      logic [KeyWidth-1:0]     key;
      logic [OffsetWidth-1:0]  record_offset;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [SlotOutWidth-1:0] slot;
      logic [OffsetWidth-1:0]  found_offset;
   } rsp_type;

   typedef struct packed {
      logic                    en;
      logic [SlotBits-1:0]     idx;
      logic [KeyWidth-1:0]     key;
      logic [OffsetWidth-1:0]  offset;
   } tbl_wr_type;

   typedef struct packed {
      logic                    valid;
      logic [KeyWidth-1:0]     key;
      logic [OffsetWidth-1:0]  offset;
   } tbl_rd_type;

   function automatic logic [SlotOutWidth-1:0] slot_out(input logic [SlotBits-1:0] idx);
      logic [SlotBits+SlotOutWidth-1:0] wide;
      wide = {{SlotOutWidth{1'b0}}, idx};
      return wide[SlotOutWidth-1:0];
   endfunction

endpackage

/* design/lphi_table.sv */
// ----------------------------------------------------------------------------
// Linear probe hash index slot table
// Slot valid bits, keys and record offsets with one probe read port.
// ----------------------------------------------------------------------------
module lphi_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [lphi_pkg::SlotBits-1:0] rd_idx,
   output lphi_pkg::tbl_rd_type         rd_data,
   input  lphi_pkg::tbl_wr_type         wr_port
);

   logic [lphi_pkg::TableSize-1:0]   valid_ff;
   logic [lphi_pkg::TableSize-1:0]   valid_in;
   logic [lphi_pkg::KeyWidth-1:0]    key_ff    [lphi_pkg::TableSize];
   logic [lphi_pkg::OffsetWidth-1:0] offset_ff [lphi_pkg::TableSize];
   lphi_pkg::tbl_rd_type             rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_port.en) begin
         valid_in[wr_port.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_port.en) begin
         key_ff[wr_port.idx]    <= wr_port.key;
         offset_ff[wr_port.idx] <= wr_port.offset;
      end
      rd_data_ff.valid  <= valid_ff[rd_idx];
      rd_data_ff.key    <= key_ff[rd_idx];
      rd_data_ff.offset <= offset_ff[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lphi_ctrl.sv */
// ----------------------------------------------------------------------------
// Linear probe hash index sequencer
// Hashes the key, walks the probe sequence one slot per cycle and holds
// the result until its transfer.
// ----------------------------------------------------------------------------
module lphi_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lphi_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lphi_pkg::rsp_type             rsp_data,
   output logic [lphi_pkg::SlotBits-1:0] rd_idx,
   input  lphi_pkg::tbl_rd_type          rd_data,
   output lphi_pkg::tbl_wr_type          wr_port
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   lphi_pkg::req_type             item_ff, item_in;
   logic [lphi_pkg::SlotBits-1:0] idx_ff, idx_in;
   logic [lphi_pkg::SlotBits-1:0] count_ff, count_in;
   lphi_pkg::rsp_type             res_ff, res_in;
   lphi_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          last_probe;
   logic                          is_insert;
   logic                          key_match;

   assign last_probe = (count_ff == lphi_pkg::SlotBits'(lphi_pkg::TableSize - 1));
   assign is_insert  = (item_ff.command == lphi_pkg::CMD_INSERT);
   assign key_match  = (rd_data.key == item_ff.key);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               idx_in   = lphi_pkg::SlotBits'(req_data.key % lphi_pkg::TableSize);
               count_in = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            res_in.slot         = '0;
            res_in.found_offset = '0;
            if (is_insert) begin
               if (!rd_data.valid) begin
                  res_in.status = lphi_pkg::STATUS_INSERTED;
                  res_in.slot   = lphi_pkg::slot_out(idx_ff);
                  state_in      = S_DONE;
               end else if (last_probe) begin
                  res_in.status = lphi_pkg::STATUS_FULL;
                  state_in      = S_DONE;
               end
            end else begin
               if (!rd_data.valid) begin
                  res_in.status = lphi_pkg::STATUS_NOT_FOUND;
                  state_in      = S_DONE;
               end else if (key_match) begin
                  res_in.status       = lphi_pkg::STATUS_FOUND;
                  res_in.slot         = lphi_pkg::slot_out(idx_ff);
                  res_in.found_offset = rd_data.offset;
                  state_in            = S_DONE;
               end else if (last_probe) begin
                  res_in.status = lphi_pkg::STATUS_NOT_FOUND;
                  state_in      = S_DONE;
               end
            end
            if (state_in == S_PROBE) begin
               count_in = count_ff + 1'b1;
               if (idx_ff == lphi_pkg::SlotBits'(lphi_pkg::TableSize - 1)) begin
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff  <= item_in;
      idx_ff   <= idx_in;
      count_ff <= count_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // The table read is registered, so the next probe index addresses it.
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rd_idx    = idx_in;

   assign wr_port.en     = (state_ff == S_PROBE) && is_insert && !rd_data.valid;
   assign wr_port.idx    = idx_ff;
   assign wr_port.key    = item_ff.key;
   assign wr_port.offset = item_ff.record_offset;

endmodule

/* design/linear_probe_hash_index_top.sv */
// ----------------------------------------------------------------------------
// Linear probe hash index
// Open-addressing hash table with linear probing over a small slot table.
//
// A request transfer carries a command, a key and a record offset. An insert
// stores key and offset in the first empty slot from the home slot (key modulo
// the table size), wrapping at the end; a search stops at an empty slot, a
// matching key or after one full lap. Each request gives one response with
// status, slot and stored offset.
// The request is taken only while the sequencer is idle. After the transfer,
// one probe is made per cycle through the single table read port and
// compare, 1 to 16 probes; then the done state moves the result into the
// output register and the sequencer returns to idle for the next request.
// A stalled response holds in the output register; a finished result then
// waits in the sequencer and no new request is taken until it moves out.
// Reset clears the slot valid bits at once, so the table is empty and a
// request can be taken in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_index_top_assert.svh"

module linear_probe_hash_index_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lphi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lphi_pkg::rsp_type rsp_data
);

   logic [lphi_pkg::SlotBits-1:0] rd_idx;
   lphi_pkg::tbl_rd_type          rd_data;
   lphi_pkg::tbl_wr_type          wr_port;

   lphi_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .wr_port (wr_port)
   );

   lphi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .rd_idx    (rd_idx),
      .rd_data   (rd_data),
      .wr_port   (wr_port)
   );

   `LPHI_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `LPHI_ASSERT_IMPL(a_write_empty_slot, clock, reset, wr_port.en, !rd_data.valid && (wr_port.idx == rd_idx))
   `LPHI_ASSERT_IMPL(a_no_write_idle, clock, reset, req_ready, !wr_port.en)
   `LPHI_ASSERT_NEXT(a_single_write, clock, reset, wr_port.en, !wr_port.en)

endmodule
